// ----- rtl/core/bdq_pkg.sv -----
// Shared types and codes for the bounded deque with search.
// No dependencies; used by bdq_front, bdq_back and the top level.
package bdq_pkg;

    // request operation codes on the func field
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_REAR  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_REAR   = 3'd3;
    localparam logic [2:0] FUNC_SEARCH     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_SEARCH,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] popped;
        logic               found;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_res;

endpackage

// ----- rtl/core/bdq_fifo.sv -----
// Two-word queue used between front and back and on the result side.
// Depends on nothing but the word type handed in as a parameter.
module bdq_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    T           r_data [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic w_wr_en;
    logic w_rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rd];
    assign w_wr_en = i_push & ~o_full;
    assign w_rd_en = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr_en) begin
                r_wr <= ~r_wr;
            end
            if (w_rd_en) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_wr_en} - {1'b0, w_rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_data[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/bdq_front.sv -----
// Front end: takes requests and decodes func into an operation word.
// Depends on bdq_pkg.
module bdq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bdq_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_cmd_valid,
    output bdq_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);

    logic          r_valid;
    logic          n_valid;
    bdq_pkg::t_cmd r_cmd;
    bdq_pkg::t_cmd n_cmd;
    logic          w_take;

    assign o_full      = r_valid & ~i_cmd_ready;
    assign w_take      = i_push & ~o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_valid     = w_take | (r_valid & ~i_cmd_ready);
        n_cmd       = r_cmd;
        if (w_take) begin
            n_cmd.value = i_req.value;
            unique case (i_req.func)
                bdq_pkg::FUNC_PUSH_FRONT: n_cmd.op = bdq_pkg::OP_PUSH_FRONT;
                bdq_pkg::FUNC_PUSH_REAR:  n_cmd.op = bdq_pkg::OP_PUSH_REAR;
                bdq_pkg::FUNC_POP_FRONT:  n_cmd.op = bdq_pkg::OP_POP_FRONT;
                bdq_pkg::FUNC_POP_REAR:   n_cmd.op = bdq_pkg::OP_POP_REAR;
                bdq_pkg::FUNC_SEARCH:     n_cmd.op = bdq_pkg::OP_SEARCH;
                default:                  n_cmd.op = bdq_pkg::OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// ----- rtl/core/bdq_back.sv -----
// Back end: ring store, head pointer and count; runs one operation at a time.
// Searches walk the held entries one memory read per cycle. Depends on bdq_pkg.
module bdq_back #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  bdq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_push,
    output bdq_pkg::t_res o_res,
    input  logic          i_res_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    // head + offset, offset <= DEPTH, folded back into the ring
    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = (s >= DEPTH_W) ? s - DEPTH_W : s;
        return t[AW-1:0];
    endfunction

    function automatic logic [4:0] f_occ(input logic [CW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[4:0];
    endfunction

    t_state         r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    bdq_pkg::t_res  r_res, n_res;
    logic [WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_left, n_left;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic             w_re;
    logic [AW-1:0]    w_raddr;

    logic [63:0]      w_val_ext;
    logic [WIDTH-1:0] w_val;
    logic [63:0]      w_rd_ext;
    logic [AW:0]      w_tail_sum;
    logic             w_is_full;
    logic             w_is_empty;

    assign w_val_ext  = {32'd0, i_cmd.value};
    assign w_val      = w_val_ext[WIDTH-1:0];
    assign w_rd_ext   = 64'(r_rdata);
    assign w_tail_sum = {1'b0, r_head} + (AW + 1)'(r_count);
    assign w_is_full  = (r_count >= DEPTH_C);
    assign w_is_empty = (r_count == '0);
    assign o_res      = r_res;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_res      = r_res;
        n_key      = r_key;
        n_idx      = r_idx;
        n_left     = r_left;
        w_we       = 1'b0;
        w_waddr    = f_wrap(w_tail_sum);
        w_re       = 1'b0;
        w_raddr    = r_idx;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop       = 1'b1;
                    n_res.popped    = '0;
                    n_res.found     = 1'b0;
                    n_res.status    = bdq_pkg::ST_OK;
                    n_res.occupancy = f_occ(r_count);
                    n_state         = S_OUT;
                    unique case (i_cmd.op)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (w_is_full) begin
                                n_res.status = bdq_pkg::ST_FULL;
                            end else begin
                                w_we            = 1'b1;
                                w_waddr         = f_prev(r_head);
                                n_head          = f_prev(r_head);
                                n_count         = r_count + 1'b1;
                                n_res.occupancy = f_occ(r_count + 1'b1);
                            end
                        end
                        bdq_pkg::OP_PUSH_REAR: begin
                            if (w_is_full) begin
                                n_res.status = bdq_pkg::ST_FULL;
                            end else begin
                                w_we            = 1'b1;
                                n_count         = r_count + 1'b1;
                                n_res.occupancy = f_occ(r_count + 1'b1);
                            end
                        end
                        bdq_pkg::OP_POP_FRONT: begin
                            if (w_is_empty) begin
                                n_res.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                w_re            = 1'b1;
                                w_raddr         = r_head;
                                n_head          = f_next(r_head);
                                n_count         = r_count - 1'b1;
                                n_res.occupancy = f_occ(r_count - 1'b1);
                                n_state         = S_READ;
                            end
                        end
                        bdq_pkg::OP_POP_REAR: begin
                            if (w_is_empty) begin
                                n_res.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                w_re            = 1'b1;
                                w_raddr         = f_wrap(w_tail_sum - 1'b1);
                                n_count         = r_count - 1'b1;
                                n_res.occupancy = f_occ(r_count - 1'b1);
                                n_state         = S_READ;
                            end
                        end
                        bdq_pkg::OP_SEARCH: begin
                            if (!w_is_empty) begin
                                // first read goes out now, compare next cycle
                                w_re    = 1'b1;
                                w_raddr = r_head;
                                n_idx   = f_next(r_head);
                                n_left  = r_count;
                                n_key   = w_val;
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            // spare codes: plain OK word, nothing touched
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res.popped = w_rd_ext[31:0];
                n_state      = S_OUT;
            end
            S_SEARCH: begin
                // r_rdata holds the entry read last cycle; r_left counts it too
                priority if (r_rdata == r_key) begin
                    n_res.found = 1'b1;
                    n_state     = S_OUT;
                end else if (r_left == CW'(1)) begin
                    n_state = S_OUT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx;
                    n_idx   = f_next(r_idx);
                    n_left  = r_left - 1'b1;
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_left <= n_left;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_val;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST)
        else $error("head pointer outside ring");

    a_search_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_left != '0) && (r_left <= $past(r_count)))
        else $error("search walk count out of range");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_cmd_valid && !w_is_empty &&
        ((i_cmd.op == bdq_pkg::OP_POP_FRONT) || (i_cmd.op == bdq_pkg::OP_POP_REAR))
        |=> (r_state == S_READ) && (r_count == $past(r_count) - 1'b1))
        else $error("pop did not read and shrink the store");

endmodule

// ----- rtl/core/bounded_deque_with_search_top.sv -----
// Top level of the bounded deque with search: front decoder, command queue,
// execution back end and result queue. Depends on bdq_pkg and the bdq_* modules.
//
//  channel   ports                     accepted when
//  request   push, full, i_req         push && !full
//  result    pop, empty, o_res         pop && !empty
//
// The back end runs one operation at a time; a search walks the held entries from the
// head, one ring read a cycle, and stops at the first match or after the last entry.
// The front register and command queue sit ahead of it and keep taking requests
// while the back end works, until they fill; the result queue holds two results.
// Reset (synchronous, active low) empties the deque; store contents are not cleared.
module bounded_deque_with_search_top #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  bdq_pkg::t_req i_req,
    input  logic          pop,
    output logic          empty,
    output bdq_pkg::t_res o_res
);

    logic          w_fe_valid;
    bdq_pkg::t_cmd w_fe_cmd;
    logic          w_cq_full;
    logic          w_cq_empty;
    bdq_pkg::t_cmd w_cq_cmd;
    logic          w_cmd_pop;
    logic          w_res_push;
    bdq_pkg::t_res w_res;
    logic          w_rq_full;

    bdq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .o_cmd_valid (w_fe_valid),
        .o_cmd       (w_fe_cmd),
        .i_cmd_ready (~w_cq_full)
    );

    bdq_fifo #(
        .T (bdq_pkg::t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_valid),
        .i_data  (w_fe_cmd),
        .o_full  (w_cq_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cq_cmd),
        .o_empty (w_cq_empty)
    );

    bdq_back #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (~w_cq_empty),
        .i_cmd       (w_cq_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_rq_full)
    );

    bdq_fifo #(
        .T (bdq_pkg::t_res)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_rq_full),
        .i_pop   (pop),
        .o_data  (o_res),
        .o_empty (empty)
    );

endmodule
